// ----- rtl/assert_macros.svh -----
// Assertion helpers used by radix_digit_converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rdc_pkg.sv -----
package rdc_pkg;

  // Port payload widths
  localparam int IN_W   = 64;
  localparam int CHAR_W = 8;

  // Conversion sizing
  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 64;
  localparam int DIGIT_AW    = $clog2(MAX_DIGITS);
  localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int DIGIT_W     = 4;
  localparam int RADIX_W     = 5;

  // Divider: DIV_STEP quotient bits per cycle
  localparam int DIV_STEP   = 8;
  localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_PAD_W  = DIV_CYCLES * DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

  // Configuration port
  localparam int APB_DW = 64;
  localparam int APB_AW = 5;

  typedef enum logic [1:0] {
    REG_BASE_SIZE  = 2'd0,
    REG_CHARS_LOW  = 2'd1,
    REG_CHARS_HIGH = 2'd2
  } reg_idx_t;

  localparam logic [RADIX_W-1:0] BASE_SIZE_RST  = 5'd10;
  localparam logic [63:0]        CHARS_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [63:0]        CHARS_HIGH_RST = 64'h6665_6463_6261_3938;

  typedef struct packed {
    logic [RADIX_W-1:0] base_size;
    logic [63:0]        chars_low;
    logic [63:0]        chars_high;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [RADIX_W-1:0] radix;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SHOW
  } rdc_state_t;

  // Clamp the programmed base into 2..16
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] b);
    logic [RADIX_W-1:0] r;
    r = b;
    if (b inside {[5'd0:5'd1]}) begin
      r = 5'd2;
    end else if (b inside {[5'd17:5'd31]}) begin
      r = 5'd16;
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d,
                                                input logic [63:0] lo,
                                                input logic [63:0] hi);
    logic [5:0] sh;
    sh = {d[2:0], 3'b000};
    return d[3] ? hi[sh +: CHAR_W] : lo[sh +: CHAR_W];
  endfunction

endpackage

// ----- rtl/rdc_if.sv -----
interface rdc_in_if;
  logic                    valid;
  logic                    ready;
  logic [rdc_pkg::IN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rdc_out_if;
  logic                      valid;
  logic                      ready;
  logic [rdc_pkg::CHAR_W-1:0] digit_char;
  logic                      last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ----- rtl/radix_digit_converter.sv -----
// Converts one unsigned 64-bit value per request into digit characters in the
// programmed base (2..16, values outside clamp), most significant first, with
// last set on the final character; zero gives a single digit, and at most 64
// digits (the least significant ones) are produced. in_ch.ready is high only
// while the block is idle. Digits are found least significant first by one
// shared restoring divider that handles 8 dividend bits per cycle; they are
// kept in a 64x4 digit RAM and read back through its registered port, each
// character read in ST_READ and then shown in ST_SHOW, where it holds while
// the sink stalls. Once the last character is taken the block returns to
// idle and accepts the next request.
// Registers (8-byte spacing): 0x00 base_size, 0x08 digit_chars_low,
// 0x10 digit_chars_high; change them only while idle.
`include "assert_macros.svh"

module radix_digit_converter (
  input  logic                       clk,
  input  logic                       rst,
  rdc_in_if.sink                     in_ch,
  rdc_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rdc_pkg::APB_AW-1:0] paddr,
  input  logic [rdc_pkg::APB_DW-1:0] pwdata,
  output logic [rdc_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  rdc_pkg::cfg_t       cfg;
  rdc_pkg::div_ctrl_t  div_ctrl;
  rdc_pkg::div_stat_t  div_stat;
  rdc_pkg::rdc_state_t state, state_next;

  logic [rdc_pkg::VALUE_WIDTH-1:0] dividend;
  logic [rdc_pkg::VALUE_WIDTH-1:0] quotient;
  logic [rdc_pkg::DIGIT_W-1:0]     remainder;
  logic [rdc_pkg::DIGIT_W-1:0]     rd_digit;
  logic [rdc_pkg::COUNT_W-1:0]     digit_count, digit_count_next;
  logic [rdc_pkg::DIGIT_AW-1:0]    emit_idx, emit_idx_next;
  logic                            ram_we;
  logic                            ram_re;

  rdc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // New value comes from the port, later dividends from the last quotient
  assign dividend = (state == rdc_pkg::ST_IDLE) ? in_ch.value[rdc_pkg::VALUE_WIDTH-1:0]
                                                : quotient;
  assign div_ctrl.radix = rdc_pkg::eff_radix(cfg.base_size);

  rdc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (dividend),
    .stat      (div_stat),
    .quotient  (quotient),
    .remainder (remainder)
  );

  rdc_digit_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (digit_count[rdc_pkg::DIGIT_AW-1:0]),
    .wdata (remainder),
    .re    (ram_re),
    .raddr (emit_idx),
    .rdata (rd_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rdc_pkg::ST_IDLE;
      digit_count <= '0;
      emit_idx    <= '0;
    end else begin
      state       <= state_next;
      digit_count <= digit_count_next;
      emit_idx    <= emit_idx_next;
    end
  end

  always_comb begin
    state_next       = state;
    digit_count_next = digit_count;
    emit_idx_next    = emit_idx;
    div_ctrl.start   = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    in_ch.ready      = 1'b0;
    out_ch.valid     = 1'b0;
    case (state)
      rdc_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          div_ctrl.start   = 1'b1;
          digit_count_next = '0;
          state_next       = rdc_pkg::ST_DIV;
        end
      end
      rdc_pkg::ST_DIV: begin
        if (div_stat.done) begin
          ram_we           = 1'b1;
          digit_count_next = digit_count + 1'b1;
          if (quotient == '0 ||
              digit_count == rdc_pkg::COUNT_W'(rdc_pkg::MAX_DIGITS - 1)) begin
            emit_idx_next = digit_count[rdc_pkg::DIGIT_AW-1:0];
            state_next    = rdc_pkg::ST_READ;
          end else begin
            div_ctrl.start = 1'b1;
          end
        end
      end
      rdc_pkg::ST_READ: begin
        ram_re     = 1'b1;
        state_next = rdc_pkg::ST_SHOW;
      end
      rdc_pkg::ST_SHOW: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          if (emit_idx == '0) begin
            state_next = rdc_pkg::ST_IDLE;
          end else begin
            emit_idx_next = emit_idx - 1'b1;
            state_next    = rdc_pkg::ST_READ;
          end
        end
      end
      default: state_next = rdc_pkg::ST_IDLE;
    endcase
  end

  // RAM read data holds while stalled, so the character holds too
  assign out_ch.digit_char = rdc_pkg::char_of(rd_digit, cfg.chars_low, cfg.chars_high);
  assign out_ch.last       = (emit_idx == '0);

  `ASSERT_IMPLIES(a_ready_excl_valid, clk, rst, in_ch.ready, !out_ch.valid,
                  "ready with output valid")
  `ASSERT_IMPLIES(a_start_when_free, clk, rst, div_ctrl.start, !div_stat.busy,
                  "divider restarted while busy")
  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1,
                  digit_count <= rdc_pkg::COUNT_W'(rdc_pkg::MAX_DIGITS), "digit count overflow")
  `ASSERT_NEXT(a_idle_after_last, clk, rst, out_ch.valid && out_ch.ready && out_ch.last,
               in_ch.ready, "not idle after last character")

endmodule

// ----- rtl/rdc_cfg_regs.sv -----
module rdc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rdc_pkg::APB_AW-1:0]  paddr,
  input  logic [rdc_pkg::APB_DW-1:0]  pwdata,
  output logic [rdc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output rdc_pkg::cfg_t               cfg
);

  rdc_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = rdc_pkg::reg_idx_t'(paddr[4:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_size  <= rdc_pkg::BASE_SIZE_RST;
      cfg.chars_low  <= rdc_pkg::CHARS_LOW_RST;
      cfg.chars_high <= rdc_pkg::CHARS_HIGH_RST;
    end else if (wr) begin
      case (idx)
        rdc_pkg::REG_BASE_SIZE:  cfg.base_size  <= pwdata[rdc_pkg::RADIX_W-1:0];
        rdc_pkg::REG_CHARS_LOW:  cfg.chars_low  <= pwdata;
        rdc_pkg::REG_CHARS_HIGH: cfg.chars_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rdc_pkg::REG_BASE_SIZE:  prdata = {{(rdc_pkg::APB_DW-rdc_pkg::RADIX_W){1'b0}},
                                         cfg.base_size};
      rdc_pkg::REG_CHARS_LOW:  prdata = cfg.chars_low;
      rdc_pkg::REG_CHARS_HIGH: prdata = cfg.chars_high;
      default:                 prdata = '0;
    endcase
  end

endmodule

// ----- rtl/rdc_divider.sv -----
// Restoring divider by a small radix, DIV_STEP dividend bits per cycle.
module rdc_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  rdc_pkg::div_ctrl_t              ctrl,
  input  logic [rdc_pkg::VALUE_WIDTH-1:0] dividend,
  output rdc_pkg::div_stat_t              stat,
  output logic [rdc_pkg::VALUE_WIDTH-1:0] quotient,
  output logic [rdc_pkg::DIGIT_W-1:0]     remainder
);

  logic [rdc_pkg::DIV_PAD_W-1:0] q, q_next;
  logic [rdc_pkg::DIGIT_W-1:0]   rem, rem_next;
  logic [rdc_pkg::RADIX_W-1:0]   radix;
  logic [rdc_pkg::DIV_CNT_W-1:0] cnt;
  logic                          busy;
  logic                          done;

  // Quotient bits shift in at the bottom as dividend bits leave the top.
  always_comb begin
    logic [rdc_pkg::DIGIT_W:0] t;
    q_next   = q;
    rem_next = rem;
    for (int i = 0; i < rdc_pkg::DIV_STEP; i++) begin
      t = {rem_next, q_next[rdc_pkg::DIV_PAD_W-1]};
      if (t >= radix) begin
        t      = t - radix;
        q_next = {q_next[rdc_pkg::DIV_PAD_W-2:0], 1'b1};
      end else begin
        q_next = {q_next[rdc_pkg::DIV_PAD_W-2:0], 1'b0};
      end
      rem_next = t[rdc_pkg::DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= rdc_pkg::DIV_CNT_W'(rdc_pkg::DIV_CYCLES - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      q     <= rdc_pkg::DIV_PAD_W'(dividend);
      rem   <= '0;
      radix <= ctrl.radix;
    end else if (busy) begin
      q   <= q_next;
      rem <= rem_next;
    end
  end

  assign quotient  = q[rdc_pkg::VALUE_WIDTH-1:0];
  assign remainder = rem;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- rtl/rdc_digit_ram.sv -----
module rdc_digit_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [rdc_pkg::DIGIT_AW-1:0] waddr,
  input  logic [rdc_pkg::DIGIT_W-1:0]  wdata,
  input  logic                         re,
  input  logic [rdc_pkg::DIGIT_AW-1:0] raddr,
  output logic [rdc_pkg::DIGIT_W-1:0]  rdata
);

  logic [rdc_pkg::DIGIT_W-1:0] mem [rdc_pkg::MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
